// ----- hw/rtl/tlsp_pkg.sv -----
`timescale 1ns / 1ps

package tlsp_pkg;

    // Parse phase codes, in the order the message is walked.
    localparam logic [4:0] PH_CTYPE    = 5'd0;
    localparam logic [4:0] PH_VER      = 5'd1;
    localparam logic [4:0] PH_RLEN     = 5'd2;
    localparam logic [4:0] PH_HTYPE    = 5'd3;
    localparam logic [4:0] PH_FIXED    = 5'd4;
    localparam logic [4:0] PH_SIDLEN   = 5'd5;
    localparam logic [4:0] PH_SID      = 5'd6;
    localparam logic [4:0] PH_CSLEN    = 5'd7;
    localparam logic [4:0] PH_CS       = 5'd8;
    localparam logic [4:0] PH_CMLEN    = 5'd9;
    localparam logic [4:0] PH_CM       = 5'd10;
    localparam logic [4:0] PH_EXTSLEN  = 5'd11;
    localparam logic [4:0] PH_EXTHDR   = 5'd12;
    localparam logic [4:0] PH_SKIP     = 5'd13;
    localparam logic [4:0] PH_SNILIST  = 5'd14;
    localparam logic [4:0] PH_SNIENTRY = 5'd15;
    localparam logic [4:0] PH_SNINAME  = 5'd16;
    localparam logic [4:0] PH_SNISKIP  = 5'd17;
    localparam logic [4:0] PH_ALPNLEN  = 5'd18;
    localparam logic [4:0] PH_ALPNPLEN = 5'd19;
    localparam logic [4:0] PH_ALPNNAME = 5'd20;
    localparam logic [4:0] PH_DONE     = 5'd21;
    localparam logic [4:0] PH_FAIL     = 5'd22;
    localparam logic [4:0] PH_CLOSED   = 5'd23;

    // Protocol constants.
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [15:0] EXT_ALPN        = 16'h0010;
    localparam logic [15:0] RECORD_HDR_BYTES = 16'd5;
    localparam logic [15:0] FIXED_SKIP      = 16'd37;
    localparam logic [16:0] POS_LIMIT       = 17'h10000;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_HS    = 2'd1;
    localparam logic [1:0] ST_NOT_HELLO = 2'd2;
    localparam logic [1:0] ST_BAD_LEN   = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_SNI     = 2'd0;
    localparam logic [1:0] KIND_ALPN    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // One queue entry: an optional name byte and an optional summary.
    typedef struct packed {
        logic        has_name;
        logic        name_alpn;
        logic [7:0]  data;
        logic        start;
        logic        has_sum;
        logic [1:0]  status;
        logic [15:0] version;
        logic [7:0]  sni_len;
        logic [4:0]  alpn_cnt;
    } tlsp_entry_t;

endpackage

// ----- hw/rtl/tlsp_front.sv -----
`timescale 1ns / 1ps

module tlsp_front #(
    parameter int SNI_MAX_BYTES  = 255,
    parameter int ALPN_MAX_BYTES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           data_byte,
    input  logic [15:0]          msg_length,
    input  logic                 first,
    input  logic                 final_req,
    input  logic                 q_ready,
    output logic                 in_ready,
    output logic                 q_push,
    output tlsp_pkg::tlsp_entry_t q_entry
);
    import tlsp_pkg::*;

    localparam int AW = (ALPN_MAX_BYTES > 2) ? $clog2(ALPN_MAX_BYTES) : 1;

    logic [16:0] pos_reg, pos_next;
    logic [4:0]  phase_reg, phase_next;
    logic [15:0] frem_reg, frem_next;
    logic [15:0] acc_reg, acc_next;
    logic [16:0] exts_end_reg, exts_end_next;
    logic [16:0] ext_end_reg, ext_end_next;
    logic [15:0] ext_type_reg, ext_type_next;
    logic [7:0]  ntype_reg, ntype_next;
    logic [15:0] nrem_reg, nrem_next;
    logic [15:0] ver_reg, ver_next;
    logic [7:0]  sni_reg, sni_next;
    logic [AW-1:0] alpn_reg, alpn_next;
    logic [1:0]  fail_reg, fail_next;

    logic        accept;
    logic        emit;
    logic        emit_alpn;
    logic        emit_start;
    logic [1:0]  st;
    logic [AW+4:0] alpn_ext;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    // Byte walker: one byte per accepted item.
    always_comb begin
        logic [16:0] n;
        logic [15:0] v16;
        logic [17:0] sum16;
        logic [17:0] sum8;
        logic        fin_field;

        pos_next      = first ? '0 : pos_reg;
        phase_next    = first ? PH_CTYPE : phase_reg;
        frem_next     = first ? '0 : frem_reg;
        acc_next      = first ? '0 : acc_reg;
        exts_end_next = first ? '0 : exts_end_reg;
        ext_end_next  = first ? '0 : ext_end_reg;
        ext_type_next = first ? '0 : ext_type_reg;
        ntype_next    = first ? '0 : ntype_reg;
        nrem_next     = first ? '0 : nrem_reg;
        ver_next      = first ? '0 : ver_reg;
        sni_next      = first ? '0 : sni_reg;
        alpn_next     = first ? '0 : alpn_reg;
        fail_next     = first ? '0 : fail_reg;
        emit          = 1'b0;
        emit_alpn     = 1'b0;
        emit_start    = 1'b0;
        st            = ST_OK;

        n   = pos_next + 17'd1;
        v16 = '0;
        sum16 = '0;
        sum8  = '0;
        fin_field = 1'b0;

        if (phase_next != PH_CLOSED) begin
            if ({1'b0, pos_next} < {2'b0, msg_length} && phase_next != PH_FAIL) begin
                case (phase_next)
                    PH_CTYPE: begin
                        if (msg_length < RECORD_HDR_BYTES) begin
                            phase_next = PH_FAIL;
                            fail_next  = ST_BAD_LEN;
                        end else if (data_byte != REC_HANDSHAKE) begin
                            phase_next = PH_FAIL;
                            fail_next  = ST_NOT_HS;
                        end else begin
                            phase_next = PH_VER;
                            frem_next  = 16'd2;
                            acc_next   = '0;
                        end
                    end
                    PH_HTYPE: begin
                        if (data_byte != HS_CLIENT_HELLO) begin
                            phase_next = PH_FAIL;
                            fail_next  = ST_NOT_HELLO;
                        end else begin
                            phase_next = PH_FIXED;
                            frem_next  = FIXED_SKIP;
                            acc_next   = '0;
                        end
                    end
                    PH_VER, PH_RLEN, PH_SIDLEN, PH_CSLEN, PH_CMLEN, PH_EXTSLEN,
                    PH_EXTHDR, PH_SNILIST, PH_SNIENTRY, PH_ALPNLEN, PH_ALPNPLEN: begin
                        acc_next = {acc_next[7:0], data_byte};
                        if (frem_next != '0) frem_next = frem_next - 16'd1;
                        if (phase_next == PH_EXTHDR && frem_next == 16'd2)
                            ext_type_next = acc_next;
                        if (phase_next == PH_SNIENTRY && frem_next == 16'd2)
                            ntype_next = data_byte;
                        fin_field = (frem_next == '0);
                    end
                    PH_FIXED, PH_SID, PH_CS, PH_CM: begin
                        if (frem_next != '0) frem_next = frem_next - 16'd1;
                        if (frem_next == '0) begin
                            acc_next = '0;
                            case (phase_next)
                                PH_FIXED: begin
                                    phase_next = PH_SIDLEN;
                                    frem_next  = 16'd1;
                                end
                                PH_SID: begin
                                    phase_next = PH_CSLEN;
                                    frem_next  = 16'd2;
                                end
                                PH_CS: begin
                                    phase_next = PH_CMLEN;
                                    frem_next  = 16'd1;
                                end
                                default: begin
                                    phase_next = PH_EXTSLEN;
                                    frem_next  = 16'd2;
                                end
                            endcase
                        end
                    end
                    PH_SNINAME: begin
                        if (sni_next < 8'(SNI_MAX_BYTES)) begin
                            emit       = 1'b1;
                            emit_start = (sni_next == '0);
                            sni_next   = sni_next + 8'd1;
                        end
                        if (nrem_next != '0) nrem_next = nrem_next - 16'd1;
                        if (nrem_next == '0) phase_next = PH_SKIP;
                    end
                    PH_SNISKIP: begin
                        if (nrem_next != '0) nrem_next = nrem_next - 16'd1;
                        if (nrem_next == '0) begin
                            if ({1'b0, n} + 18'd3 > {1'b0, ext_end_next}) begin
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_SNIENTRY;
                                frem_next  = 16'd3;
                                acc_next   = '0;
                            end
                        end
                    end
                    PH_ALPNNAME: begin
                        if ({1'b0, alpn_next} < (AW+1)'(ALPN_MAX_BYTES - 1)) begin
                            emit       = 1'b1;
                            emit_alpn  = 1'b1;
                            emit_start = (alpn_next == '0);
                            alpn_next  = alpn_next + AW'(1);
                        end
                        if (nrem_next != '0) nrem_next = nrem_next - 16'd1;
                        if (nrem_next == '0) phase_next = PH_SKIP;
                    end
                    default: begin
                    end
                endcase

                // A length field is complete: act on its value.
                if (fin_field) begin
                    v16   = acc_next;
                    sum16 = {1'b0, n} + {2'b0, v16};
                    sum8  = {1'b0, n} + {10'b0, v16[7:0]};
                    case (phase_next)
                        PH_VER: begin
                            ver_next   = v16;
                            phase_next = PH_RLEN;
                            frem_next  = 16'd2;
                            acc_next   = '0;
                        end
                        PH_RLEN: begin
                            if (sum16 > {2'b0, msg_length}) begin
                                phase_next = PH_FAIL;
                                fail_next  = ST_BAD_LEN;
                            end else begin
                                phase_next = PH_HTYPE;
                            end
                        end
                        PH_SIDLEN: begin
                            acc_next = '0;
                            if (v16[7:0] == '0) begin
                                phase_next = PH_CSLEN;
                                frem_next  = 16'd2;
                            end else begin
                                phase_next = PH_SID;
                                frem_next  = {8'b0, v16[7:0]};
                            end
                        end
                        PH_CSLEN: begin
                            acc_next = '0;
                            if (v16 == '0) begin
                                phase_next = PH_CMLEN;
                                frem_next  = 16'd1;
                            end else begin
                                phase_next = PH_CS;
                                frem_next  = v16;
                            end
                        end
                        PH_CMLEN: begin
                            acc_next = '0;
                            if (v16[7:0] == '0) begin
                                phase_next = PH_EXTSLEN;
                                frem_next  = 16'd2;
                            end else begin
                                phase_next = PH_CM;
                                frem_next  = {8'b0, v16[7:0]};
                            end
                        end
                        PH_EXTSLEN: begin
                            if (sum16 > {2'b0, msg_length}) begin
                                phase_next = PH_FAIL;
                                fail_next  = ST_BAD_LEN;
                            end else begin
                                exts_end_next = sum16[16:0];
                                if ({1'b0, n} + 18'd4 <= sum16) begin
                                    phase_next = PH_EXTHDR;
                                    frem_next  = 16'd4;
                                    acc_next   = '0;
                                end else begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                        PH_EXTHDR: begin
                            if (sum16 > {1'b0, exts_end_next}) begin
                                phase_next = PH_DONE;
                            end else begin
                                ext_end_next = sum16[16:0];
                                if (ext_type_next == EXT_SERVER_NAME && v16 >= 16'd2) begin
                                    phase_next = PH_SNILIST;
                                    frem_next  = 16'd2;
                                    acc_next   = '0;
                                end else if (ext_type_next == EXT_ALPN && v16 >= 16'd2) begin
                                    phase_next = PH_ALPNLEN;
                                    frem_next  = 16'd2;
                                    acc_next   = '0;
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        PH_SNILIST: begin
                            if (sum16 > {1'b0, ext_end_next}) begin
                                phase_next = PH_SKIP;
                            end else if ({1'b0, n} + 18'd3 > {1'b0, ext_end_next}) begin
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_SNIENTRY;
                                frem_next  = 16'd3;
                                acc_next   = '0;
                            end
                        end
                        PH_SNIENTRY: begin
                            if (sum16 > {1'b0, ext_end_next}) begin
                                phase_next = PH_SKIP;
                            end else if (ntype_next == '0) begin
                                sni_next   = '0;
                                nrem_next  = v16;
                                phase_next = (v16 != '0) ? PH_SNINAME : PH_SKIP;
                            end else if (v16 == '0) begin
                                if ({1'b0, n} + 18'd3 > {1'b0, ext_end_next}) begin
                                    phase_next = PH_SKIP;
                                end else begin
                                    phase_next = PH_SNIENTRY;
                                    frem_next  = 16'd3;
                                    acc_next   = '0;
                                end
                            end else begin
                                nrem_next  = v16;
                                phase_next = PH_SNISKIP;
                            end
                        end
                        PH_ALPNLEN: begin
                            if (sum16 > {1'b0, ext_end_next}) begin
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_ALPNPLEN;
                                frem_next  = 16'd1;
                                acc_next   = '0;
                            end
                        end
                        PH_ALPNPLEN: begin
                            if (sum8 > {1'b0, ext_end_next}) begin
                                phase_next = PH_SKIP;
                            end else begin
                                alpn_next  = '0;
                                nrem_next  = {8'b0, v16[7:0]};
                                phase_next = (v16[7:0] != '0) ? PH_ALPNNAME : PH_SKIP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // Leaving the current extension at its end.
                if (phase_next >= PH_SKIP && phase_next <= PH_ALPNNAME &&
                    n >= ext_end_next) begin
                    if ({1'b0, ext_end_next} + 18'd4 <= {1'b0, exts_end_next}) begin
                        phase_next = PH_EXTHDR;
                        frem_next  = 16'd4;
                        acc_next   = '0;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end
            if (pos_next < POS_LIMIT) pos_next = pos_next + 17'd1;
        end

        // Close the message on the final byte and settle its status.
        if (final_req) begin
            if (phase_next != PH_CLOSED) begin
                if (phase_next == PH_FAIL)
                    st = fail_next;
                else if (n < {1'b0, msg_length})
                    st = ST_BAD_LEN;
                else if (phase_next >= PH_EXTSLEN && phase_next <= PH_DONE)
                    st = ST_OK;
                else
                    st = ST_BAD_LEN;
                fail_next = st;
                if (st != ST_OK) begin
                    ver_next  = '0;
                    sni_next  = '0;
                    alpn_next = '0;
                end
                phase_next = PH_CLOSED;
            end
        end
    end

    // Queue entry for this byte.
    assign alpn_ext = (AW+5)'(alpn_next);
    assign q_push   = accept && (emit || final_req);
    always_comb begin
        q_entry.has_name  = emit;
        q_entry.name_alpn = emit_alpn;
        q_entry.data      = data_byte;
        q_entry.start     = emit_start;
        q_entry.has_sum   = final_req;
        q_entry.status    = fail_next;
        q_entry.version   = ver_next;
        q_entry.sni_len   = sni_next;
        q_entry.alpn_cnt  = alpn_ext[4:0];
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            phase_reg    <= PH_CTYPE;
            frem_reg     <= '0;
            acc_reg      <= '0;
            exts_end_reg <= '0;
            ext_end_reg  <= '0;
            ext_type_reg <= '0;
            ntype_reg    <= '0;
            nrem_reg     <= '0;
            ver_reg      <= '0;
            sni_reg      <= '0;
            alpn_reg     <= '0;
            fail_reg     <= '0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            frem_reg     <= frem_next;
            acc_reg      <= acc_next;
            exts_end_reg <= exts_end_next;
            ext_end_reg  <= ext_end_next;
            ext_type_reg <= ext_type_next;
            ntype_reg    <= ntype_next;
            nrem_reg     <= nrem_next;
            ver_reg      <= ver_next;
            sni_reg      <= sni_next;
            alpn_reg     <= alpn_next;
            fail_reg     <= fail_next;
        end
    end

endmodule

// ----- hw/rtl/tlsp_queue.sv -----
`timescale 1ns / 1ps

module tlsp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tlsp_pkg::tlsp_entry_t push_entry,
    output logic                 not_full,
    input  logic                 pop,
    output logic                 head_valid,
    output tlsp_pkg::tlsp_entry_t head_entry
);
    import tlsp_pkg::*;

    localparam int DEPTH = 4;

    tlsp_entry_t slot_reg [DEPTH];
    logic [1:0]  wr_reg, wr_next;
    logic [1:0]  rd_reg, rd_next;
    logic [2:0]  cnt_reg, cnt_next;

    assign not_full   = (cnt_reg != 3'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = slot_reg[rd_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_next  = push ? wr_reg + 2'd1 : wr_reg;
        rd_next  = pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_reg] <= push_entry;
    end

endmodule

// ----- hw/rtl/tlsp_back.sv -----
`timescale 1ns / 1ps

module tlsp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  tlsp_pkg::tlsp_entry_t head_entry,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           kind,
    output logic [7:0]           out_byte,
    output logic                 run_start,
    output logic [1:0]           status,
    output logic                 detected,
    output logic [15:0]          record_version,
    output logic [7:0]           sni_length,
    output logic [4:0]           alpn_length,
    output logic                 run_last
);
    import tlsp_pkg::*;

    logic        valid_reg, valid_next;
    logic        sub_reg, sub_next;
    logic        load;
    logic        name_turn;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic        start_reg, start_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] ver_reg, ver_next;
    logic [7:0]  sni_reg, sni_next;
    logic [4:0]  alpn_reg, alpn_next;
    logic        last_reg, last_next;

    assign load      = !valid_reg || m_ready;
    assign name_turn = head_entry.has_name && !sub_reg;

    // Split each entry into its name result and its summary result.
    always_comb begin
        valid_next  = valid_reg && !m_ready;
        sub_next    = sub_reg;
        pop         = 1'b0;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        start_next  = start_reg;
        status_next = status_reg;
        ver_next    = ver_reg;
        sni_next    = sni_reg;
        alpn_next   = alpn_reg;
        last_next   = last_reg;
        if (load && head_valid) begin
            valid_next = 1'b1;
            if (name_turn) begin
                kind_next   = head_entry.name_alpn ? KIND_ALPN : KIND_SNI;
                byte_next   = head_entry.data;
                start_next  = head_entry.start;
                status_next = ST_OK;
                ver_next    = '0;
                sni_next    = '0;
                alpn_next   = '0;
                last_next   = !head_entry.has_sum;
                if (head_entry.has_sum) sub_next = 1'b1;
                else pop = 1'b1;
            end else begin
                kind_next   = KIND_SUMMARY;
                byte_next   = '0;
                start_next  = 1'b0;
                status_next = head_entry.status;
                ver_next    = head_entry.version;
                sni_next    = head_entry.sni_len;
                alpn_next   = head_entry.alpn_cnt;
                last_next   = 1'b1;
                sub_next    = 1'b0;
                pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        start_reg  <= start_next;
        status_reg <= status_next;
        ver_reg    <= ver_next;
        sni_reg    <= sni_next;
        alpn_reg   <= alpn_next;
        last_reg   <= last_next;
    end

    assign m_valid        = valid_reg;
    assign kind           = kind_reg;
    assign out_byte       = byte_reg;
    assign run_start      = start_reg;
    assign status         = status_reg;
    assign detected       = (kind_reg == KIND_SUMMARY) && (status_reg == ST_OK);
    assign record_version = ver_reg;
    assign sni_length     = sni_reg;
    assign alpn_length    = alpn_reg;
    assign run_last       = last_reg;

endmodule

// ----- hw/rtl/tls_client_hello_sni_alpn_parser.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_*       in         data_byte, msg_length, first, final_req
// m_*       out        kind, out_byte, run_start, status, detected,
//                      record_version, sni_length, alpn_length, run_last
//
// The parser takes one byte per clock while the queue has room; its state updates in that cycle.
// A byte that yields a name result and a summary gives two results, name first,
// drained by the single output register one result per clock while m_ready is high.
// A four-entry queue between parser and output lets either side stall alone.
// Reset is synchronous and active low; no clearing pass is needed.
module tls_client_hello_sni_alpn_parser #(
    parameter int SNI_MAX_BYTES  = 255,
    parameter int ALPN_MAX_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [15:0] s_msg_length,
    input  logic        s_first,
    input  logic        s_final_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_run_start,
    output logic [1:0]  m_status,
    output logic        m_detected,
    output logic [15:0] m_record_version,
    output logic [7:0]  m_sni_length,
    output logic [4:0]  m_alpn_length,
    output logic        m_run_last
);
    import tlsp_pkg::*;

    logic        q_push;
    logic        q_not_full;
    logic        q_pop;
    logic        q_head_valid;
    tlsp_entry_t q_in_entry;
    tlsp_entry_t q_head_entry;

    // Byte parser.
    tlsp_front #(
        .SNI_MAX_BYTES (SNI_MAX_BYTES),
        .ALPN_MAX_BYTES(ALPN_MAX_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .data_byte (s_data_byte),
        .msg_length(s_msg_length),
        .first     (s_first),
        .final_req (s_final_req),
        .q_ready   (q_not_full),
        .in_ready  (s_ready),
        .q_push    (q_push),
        .q_entry   (q_in_entry)
    );

    // Result queue.
    tlsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_in_entry),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head_valid(q_head_valid),
        .head_entry(q_head_entry)
    );

    // Result emitter.
    tlsp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_head_valid),
        .head_entry    (q_head_entry),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .kind          (m_kind),
        .out_byte      (m_out_byte),
        .run_start     (m_run_start),
        .status        (m_status),
        .detected      (m_detected),
        .record_version(m_record_version),
        .sni_length    (m_sni_length),
        .alpn_length   (m_alpn_length),
        .run_last      (m_run_last)
    );

endmodule
